// ===== hw/rtl/merc_pkg.sv =====
// Shared constants, command codes and queue head type for the ellipse rasteriser.
package merc_pkg;

  localparam int COORD_BITS_DEF  = 12;
  localparam int RADIUS_BITS_DEF = 11;
  localparam int COLOR_BITS      = 24;
  localparam int QUEUE_DEPTH     = 2;

  localparam logic REQ_START   = 1'b0;
  localparam logic REQ_ADVANCE = 1'b1;

  typedef enum logic [1:0] {
    CMD_START,
    CMD_STOP,
    CMD_ADVANCE
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } q_head_t;

endpackage

// ===== hw/rtl/merc_if.sv =====
// Request and pixel channel interfaces of the ellipse rasteriser.
interface merc_in_if #(
  parameter int COORD_BITS  = merc_pkg::COORD_BITS_DEF,
  parameter int RADIUS_BITS = merc_pkg::RADIUS_BITS_DEF
);
  logic                            valid;
  logic                            ready;
  logic                            req_type;
  logic [COORD_BITS-1:0]           center_x;
  logic [COORD_BITS-1:0]           center_y;
  logic [RADIUS_BITS-1:0]          radius_x;
  logic [RADIUS_BITS-1:0]          radius_y;
  logic [merc_pkg::COLOR_BITS-1:0] color;

  modport source (output valid, req_type, center_x, center_y, radius_x, radius_y, color,
                  input ready);
  modport sink (input valid, req_type, center_x, center_y, radius_x, radius_y, color,
                output ready);
endinterface

interface merc_out_if #(
  parameter int COORD_BITS = merc_pkg::COORD_BITS_DEF
);
  logic                            valid;
  logic                            ready;
  logic signed [COORD_BITS+1:0]    px_right;
  logic signed [COORD_BITS+1:0]    px_left;
  logic signed [COORD_BITS+1:0]    py_down;
  logic signed [COORD_BITS+1:0]    py_up;
  logic [merc_pkg::COLOR_BITS-1:0] pixel_color;
  logic                            last_point;

  modport source (output valid, px_right, px_left, py_down, py_up, pixel_color, last_point,
                  input ready);
  modport sink (input valid, px_right, px_left, py_down, py_up, pixel_color, last_point,
                output ready);
endinterface

// ===== hw/rtl/merc_front.sv =====
// Front end: accepts request beats, classifies them and holds them in a short queue.
module merc_front #(
  parameter int COORD_BITS  = merc_pkg::COORD_BITS_DEF,
  parameter int RADIUS_BITS = merc_pkg::RADIUS_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  merc_in_if.sink                         in_ch,
  input  logic                            pop,
  output merc_pkg::q_head_t               head,
  output logic [COORD_BITS-1:0]           head_cx,
  output logic [COORD_BITS-1:0]           head_cy,
  output logic [RADIUS_BITS-1:0]          head_rx,
  output logic [RADIUS_BITS-1:0]          head_ry,
  output logic [merc_pkg::COLOR_BITS-1:0] head_color
);
  import merc_pkg::*;

  localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  cmd_t                   q_cmd_r [QUEUE_DEPTH];
  logic [COORD_BITS-1:0]  q_cx_r  [QUEUE_DEPTH];
  logic [COORD_BITS-1:0]  q_cy_r  [QUEUE_DEPTH];
  logic [RADIUS_BITS-1:0] q_rx_r  [QUEUE_DEPTH];
  logic [RADIUS_BITS-1:0] q_ry_r  [QUEUE_DEPTH];
  logic [COLOR_BITS-1:0]  q_col_r [QUEUE_DEPTH];

  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          push;
  cmd_t          in_cmd;

  // zero radius on a start just stops whatever ellipse is running
  always_comb begin
    unique case (in_ch.req_type)
      REQ_ADVANCE: in_cmd = CMD_ADVANCE;
      REQ_START: begin
        if ((in_ch.radius_x == '0) || (in_ch.radius_y == '0)) begin
          in_cmd = CMD_STOP;
        end else begin
          in_cmd = CMD_START;
        end
      end
      default: in_cmd = CMD_ADVANCE;
    endcase
  end

  assign in_ch.ready = (cnt_r != CW'(QUEUE_DEPTH));
  assign push        = in_ch.valid && in_ch.ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    cnt_nxt = cnt_r + CW'(push) - CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_cmd_r[wr_ptr_r] <= in_cmd;
      q_cx_r[wr_ptr_r]  <= in_ch.center_x;
      q_cy_r[wr_ptr_r]  <= in_ch.center_y;
      q_rx_r[wr_ptr_r]  <= in_ch.radius_x;
      q_ry_r[wr_ptr_r]  <= in_ch.radius_y;
      q_col_r[wr_ptr_r] <= in_ch.color;
    end
  end

  assign head.valid = (cnt_r != '0);
  assign head.cmd   = q_cmd_r[rd_ptr_r];
  assign head_cx    = q_cx_r[rd_ptr_r];
  assign head_cy    = q_cy_r[rd_ptr_r];
  assign head_rx    = q_rx_r[rd_ptr_r];
  assign head_ry    = q_ry_r[rd_ptr_r];
  assign head_color = q_col_r[rd_ptr_r];

`ifndef NO_ASSERTIONS
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> head.valid)
    else $error("queue popped while empty");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(QUEUE_DEPTH))
    else $error("queue fill count beyond depth");

  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == '0) |-> (wr_ptr_r == rd_ptr_r))
    else $error("empty queue with pointers apart");
`endif

endmodule

// ===== hw/rtl/merc_back.sv =====
// Back end: ellipse sequencer with shared multiplier, midpoint stepping and output register.
module merc_back #(
  parameter int COORD_BITS  = merc_pkg::COORD_BITS_DEF,
  parameter int RADIUS_BITS = merc_pkg::RADIUS_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  merc_pkg::q_head_t               head,
  input  logic [COORD_BITS-1:0]           head_cx,
  input  logic [COORD_BITS-1:0]           head_cy,
  input  logic [RADIUS_BITS-1:0]          head_rx,
  input  logic [RADIUS_BITS-1:0]          head_ry,
  input  logic [merc_pkg::COLOR_BITS-1:0] head_color,
  output logic                            pop,
  merc_out_if.source                      out_ch
);
  import merc_pkg::*;

  localparam int RB  = RADIUS_BITS;
  localparam int OW  = COORD_BITS + 2;   // pixel field width
  localparam int OFW = RB + 1;           // x / y offset
  localparam int SQW = 2 * RB;           // squared radius, multiplier port A
  localparam int TW  = 2 * RB + 4;       // squared term, multiplier port B
  localparam int PW  = 4 * RB + 4;       // product
  localparam int ABW = 4 * RB;           // a^2 * b^2
  localparam int GW  = 3 * RB + 3;       // gradients
  localparam int DW  = 4 * RB + 6;       // decision, four times the real value

  typedef enum logic [3:0] {
    S_RUN,
    S_ASQ,
    S_BSQ,
    S_AB,
    S_ABSQ,
    S_ARM,
    S_TX,
    S_TY,
    S_P1,
    S_P2,
    S_P3
  } state_t;

  state_t                  state_r;
  logic                    active_r;
  logic                    region2_r;
  logic [COORD_BITS-1:0]   cx_r, cy_r;
  logic [RB-1:0]           ra_r, rb_r;
  logic [OFW-1:0]          xo_r, yo_r;
  logic [SQW-1:0]          asq_r, bsq_r;
  logic [ABW-1:0]          absq_r;
  logic [TW-1:0]           t_r;
  logic [PW-1:0]           prod_r;
  logic signed [GW-1:0]    gx_r, gy_r;
  logic signed [DW-1:0]    dec_r;
  logic [COLOR_BITS-1:0]   col_r;

  logic                    out_valid_r;
  logic signed [OW-1:0]    px_right_r, px_left_r, py_down_r, py_up_r;
  logic [COLOR_BITS-1:0]   pix_col_r;
  logic                    last_r;

  logic                    slot_free, to_r2, is_last, emit, enter_r2;
  logic [SQW-1:0]          mul_a;
  logic [TW-1:0]           mul_b;
  logic [PW-1:0]           mul_p;
  logic [OFW:0]            tx;
  logic [OFW-1:0]          ty_abs;
  logic signed [GW-1:0]    asq2_g, bsq2_g, gx_step, gy_step;
  logic signed [DW-1:0]    gx_d, gy_d, asq_d, bsq_d, prod_d, absq_d, dterm;
  logic [OFW-1:0]          xo_nxt, yo_nxt;
  logic signed [GW-1:0]    gx_nxt, gy_nxt;
  logic signed [DW-1:0]    dec_nxt;

  assign slot_free = !out_valid_r || out_ch.ready;
  assign to_r2     = !region2_r && !(gx_r < gy_r);
  assign is_last   = region2_r && (yo_r == '0);

  always_comb begin
    pop      = 1'b0;
    emit     = 1'b0;
    enter_r2 = 1'b0;
    if ((state_r == S_RUN) && head.valid) begin
      unique case (head.cmd)
        CMD_START, CMD_STOP: pop = 1'b1;
        CMD_ADVANCE: begin
          if (!active_r) begin
            pop = 1'b1;
          end else if (to_r2) begin
            // the beat stays at the head until region two is set up
            enter_r2 = 1'b1;
          end else if (slot_free) begin
            pop  = 1'b1;
            emit = 1'b1;
          end
        end
        default: pop = 1'b1;
      endcase
    end
  end

  // shared multiplier, one product per cycle
  assign tx     = {xo_r, 1'b1};
  assign ty_abs = (yo_r == '0) ? OFW'(1) : yo_r - 1'b1;

  always_comb begin
    unique case (state_r)
      S_ASQ: begin mul_a = SQW'(ra_r);   mul_b = TW'(ra_r);   end
      S_BSQ: begin mul_a = SQW'(rb_r);   mul_b = TW'(rb_r);   end
      S_AB:  begin mul_a = asq_r;        mul_b = TW'(rb_r);   end
      S_ABSQ: begin mul_a = asq_r;       mul_b = TW'(bsq_r);  end
      S_TX:  begin mul_a = SQW'(tx);     mul_b = TW'(tx);     end
      S_TY:  begin mul_a = SQW'(ty_abs); mul_b = TW'(ty_abs); end
      S_P1:  begin mul_a = bsq_r;        mul_b = t_r;         end
      S_P2:  begin mul_a = asq_r;        mul_b = t_r;         end
      default: begin mul_a = '0;         mul_b = '0;          end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // midpoint step
  assign asq2_g  = $signed({{(GW-SQW-1){1'b0}}, asq_r, 1'b0});
  assign bsq2_g  = $signed({{(GW-SQW-1){1'b0}}, bsq_r, 1'b0});
  assign gx_step = gx_r + bsq2_g;
  assign gy_step = gy_r - asq2_g;
  assign gx_d    = {{(DW-GW){gx_step[GW-1]}}, gx_step};
  assign gy_d    = {{(DW-GW){gy_step[GW-1]}}, gy_step};
  assign asq_d   = $signed({{(DW-SQW){1'b0}}, asq_r});
  assign bsq_d   = $signed({{(DW-SQW){1'b0}}, bsq_r});
  assign prod_d  = $signed({{(DW-PW){1'b0}}, prod_r});
  assign absq_d  = $signed({{(DW-ABW){1'b0}}, absq_r});

  always_comb begin
    if (!region2_r) begin
      xo_nxt = xo_r + 1'b1;
      gx_nxt = gx_step;
      if (dec_r[DW-1]) begin
        yo_nxt = yo_r;
        gy_nxt = gy_r;
        dterm  = gx_d + bsq_d;
      end else begin
        yo_nxt = yo_r - 1'b1;
        gy_nxt = gy_step;
        dterm  = gx_d - gy_d + bsq_d;
      end
    end else begin
      yo_nxt = yo_r - 1'b1;
      gy_nxt = gy_step;
      if (!dec_r[DW-1] && (dec_r != '0)) begin
        xo_nxt = xo_r;
        gx_nxt = gx_r;
        dterm  = asq_d - gy_d;
      end else begin
        xo_nxt = xo_r + 1'b1;
        gx_nxt = gx_step;
        dterm  = gx_d - gy_d + asq_d;
      end
    end
    dec_nxt = dec_r + (dterm <<< 2);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_RUN;
      active_r    <= 1'b0;
      region2_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      prod_r <= mul_p;

      if (emit) begin
        out_valid_r <= 1'b1;
        px_right_r  <= OW'(cx_r) + OW'(xo_r);
        px_left_r   <= OW'(cx_r) - OW'(xo_r);
        py_down_r   <= OW'(cy_r) + OW'(yo_r);
        py_up_r     <= OW'(cy_r) - OW'(yo_r);
        pix_col_r   <= col_r;
        last_r      <= is_last;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_RUN: begin
          if (enter_r2) begin
            region2_r <= 1'b1;
            state_r   <= S_TX;
          end else if (pop) begin
            unique case (head.cmd)
              CMD_START: begin
                active_r  <= 1'b0;
                region2_r <= 1'b0;
                cx_r      <= head_cx;
                cy_r      <= head_cy;
                col_r     <= head_color;
                ra_r      <= head_rx;
                rb_r      <= head_ry;
                xo_r      <= '0;
                yo_r      <= OFW'(head_ry);
                gx_r      <= '0;
                state_r   <= S_ASQ;
              end
              CMD_STOP: active_r <= 1'b0;
              CMD_ADVANCE: begin
                if (emit) begin
                  if (is_last) begin
                    active_r <= 1'b0;
                  end else begin
                    xo_r  <= xo_nxt;
                    yo_r  <= yo_nxt;
                    gx_r  <= gx_nxt;
                    gy_r  <= gy_nxt;
                    dec_r <= dec_nxt;
                  end
                end
              end
              default: active_r <= 1'b0;
            endcase
          end
        end
        S_ASQ: state_r <= S_BSQ;
        S_BSQ: begin
          asq_r   <= prod_r[SQW-1:0];
          state_r <= S_AB;
        end
        S_AB: begin
          bsq_r   <= prod_r[SQW-1:0];
          state_r <= S_ABSQ;
        end
        S_ABSQ: begin
          // product holds a^2 * b
          gy_r    <= $signed({prod_r[GW-2:0], 1'b0});
          dec_r   <= (bsq_d <<< 2) - (prod_d <<< 2) + asq_d;
          state_r <= S_ARM;
        end
        S_ARM: begin
          absq_r   <= prod_r[ABW-1:0];
          active_r <= 1'b1;
          state_r  <= S_RUN;
        end
        S_TX: state_r <= S_TY;
        S_TY: begin
          t_r     <= prod_r[TW-1:0];
          state_r <= S_P1;
        end
        S_P1: begin
          t_r     <= prod_r[TW-1:0];
          state_r <= S_P2;
        end
        S_P2: begin
          dec_r   <= prod_d;
          state_r <= S_P3;
        end
        S_P3: begin
          dec_r   <= dec_r + (prod_d <<< 2) - (absq_d <<< 2);
          state_r <= S_RUN;
        end
        default: state_r <= S_RUN;
      endcase
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.px_right    = px_right_r;
  assign out_ch.px_left     = px_left_r;
  assign out_ch.py_down     = py_down_r;
  assign out_ch.py_up       = py_up_r;
  assign out_ch.pixel_color = pix_col_r;
  assign out_ch.last_point  = last_r;

`ifndef NO_ASSERTIONS
  a_no_pop_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_RUN) |-> !pop)
    else $error("queue popped while sequencer busy");

  a_arm: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ARM) |=> (active_r && (state_r == S_RUN)))
    else $error("start setup did not arm the ellipse");

  a_r2_setup: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_TX) |-> (region2_r && active_r))
    else $error("region two setup outside an active ellipse");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    emit |-> (!out_valid_r || out_ch.ready))
    else $error("pending output beat overwritten");
`endif

endmodule

// ===== hw/rtl/midpoint_ellipse_raster_core.sv =====
// Top level of the midpoint ellipse rasteriser: front queue and back sequencer.
//
// A start beat (req_type 0) loads centre, radii and colour and gives no pixel beat; a start
// with either radius zero just leaves the block idle. Each advance beat (req_type 1) gives
// the next quadrant point as four mirrored coordinates, last_point set on the point with
// y offset zero; an advance while idle gives nothing. Beats pass through a two-entry queue
// into the back end, reaching it in the cycle after acceptance at the earliest. A point a
// cycle is sustained over advances of either region while the output is taken; a start
// holds the back end in S_ASQ through S_ARM while the shared registered multiplier works
// out a^2, b^2, a^2*b and a^2*b^2 in turn, and the crossing into region two runs once per
// ellipse through S_TX to S_P3 for the products of the region-two decision. Zero-radius
// starts and idle advances leave the back end in S_RUN. The input keeps accepting while
// the queue has room, and the registered output lets a finished point wait for its sink.
module midpoint_ellipse_raster_core #(
  parameter int COORD_BITS  = merc_pkg::COORD_BITS_DEF,
  parameter int RADIUS_BITS = merc_pkg::RADIUS_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  merc_in_if.sink    in_ch,
  merc_out_if.source out_ch
);
  import merc_pkg::*;

  q_head_t                head;
  logic                   pop;
  logic [COORD_BITS-1:0]  head_cx, head_cy;
  logic [RADIUS_BITS-1:0] head_rx, head_ry;
  logic [COLOR_BITS-1:0]  head_color;

  merc_front #(
    .COORD_BITS  (COORD_BITS),
    .RADIUS_BITS (RADIUS_BITS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .pop        (pop),
    .head       (head),
    .head_cx    (head_cx),
    .head_cy    (head_cy),
    .head_rx    (head_rx),
    .head_ry    (head_ry),
    .head_color (head_color)
  );

  merc_back #(
    .COORD_BITS  (COORD_BITS),
    .RADIUS_BITS (RADIUS_BITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .head_cx    (head_cx),
    .head_cy    (head_cy),
    .head_rx    (head_rx),
    .head_ry    (head_ry),
    .head_color (head_color),
    .pop        (pop),
    .out_ch     (out_ch)
  );

endmodule

// ===== sim/midpoint_ellipse_raster_core_tb.sv =====
// Testbench for midpoint_ellipse_raster_core: directed and random ellipses against a local predictor.
module midpoint_ellipse_raster_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import merc_pkg::*;

  localparam int CW = COORD_BITS_DEF;
  localparam int RW = RADIUS_BITS_DEF;
  localparam int OW = COORD_BITS_DEF + 2;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int TAIL_CYCLES = 20;
  localparam int RANDOM_ITEMS = 700;

  typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_SINK, IDLE_BOTH} idling_t;

  typedef struct packed {
    logic                  req_type;
    logic [CW-1:0]         cx;
    logic [CW-1:0]         cy;
    logic [RW-1:0]         rx;
    logic [RW-1:0]         ry;
    logic [COLOR_BITS-1:0] colour;
  } req_t;

  typedef struct {
    logic signed [OW-1:0]  right;
    logic signed [OW-1:0]  left;
    logic signed [OW-1:0]  down;
    logic signed [OW-1:0]  up;
    logic [COLOR_BITS-1:0] colour;
    logic                  last;
  } pixel_t;

  logic clk;
  logic rst_n;

  merc_in_if  req_bus ();
  merc_out_if pixel_bus ();

  midpoint_ellipse_raster_core dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (req_bus),
    .out_ch (pixel_bus)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // predicted rasteriser state
  bit                    tracing;
  bit                    second_region;
  logic [CW-1:0]         ctr_x;
  logic [CW-1:0]         ctr_y;
  logic [COLOR_BITS-1:0] ink;
  longint                x_step;
  longint                y_step;
  longint                rx_sq;
  longint                ry_sq;
  longint                slope_x;
  longint                slope_y;
  longint                mid_err;

  pixel_t pending_pixels[$];
  int     mismatches;
  int     gap_pct;
  int     stall_pct;
  int     quiet_cycles;

  function automatic void trace_request(input req_t r);
    longint a;
    longint b;
    longint tx;
    longint ty;
    pixel_t p;
    if (r.req_type == REQ_START) begin
      a = longint'(r.rx);
      b = longint'(r.ry);
      if (a == 0 || b == 0) begin
        tracing = 1'b0;
        return;
      end
      ctr_x = r.cx;
      ctr_y = r.cy;
      ink = r.colour;
      rx_sq = a * a;
      ry_sq = b * b;
      x_step = 0;
      y_step = b;
      slope_x = 0;
      slope_y = 2 * rx_sq * b;
      mid_err = 4 * ry_sq - 4 * rx_sq * b + rx_sq;
      second_region = 1'b0;
      tracing = 1'b1;
      return;
    end
    if (!tracing) return;
    // decision held at four times its real value
    if (!second_region && !(slope_x < slope_y)) begin
      tx = 2 * x_step + 1;
      ty = y_step - 1;
      second_region = 1'b1;
      mid_err = ry_sq * tx * tx + 4 * rx_sq * ty * ty - 4 * rx_sq * ry_sq;
    end
    p.right = OW'(longint'(ctr_x) + x_step);
    p.left = OW'(longint'(ctr_x) - x_step);
    p.down = OW'(longint'(ctr_y) + y_step);
    p.up = OW'(longint'(ctr_y) - y_step);
    p.colour = ink;
    p.last = second_region && (y_step == 0);
    pending_pixels.push_back(p);
    if (p.last) begin
      tracing = 1'b0;
      return;
    end
    if (!second_region) begin
      x_step++;
      slope_x += 2 * ry_sq;
      if (mid_err < 0) begin
        mid_err += 4 * (slope_x + ry_sq);
      end else begin
        y_step--;
        slope_y -= 2 * rx_sq;
        mid_err += 4 * (slope_x - slope_y + ry_sq);
      end
    end else begin
      y_step--;
      slope_y -= 2 * rx_sq;
      if (mid_err > 0) begin
        mid_err += 4 * (rx_sq - slope_y);
      end else begin
        x_step++;
        slope_x += 2 * ry_sq;
        mid_err += 4 * (slope_x - slope_y + rx_sq);
      end
    end
  endfunction

  task automatic set_idling(input idling_t mode);
    case (mode)
      IDLE_NONE: begin
        gap_pct = 0;
        stall_pct = 0;
      end
      IDLE_SENDER: begin
        gap_pct = 50;
        stall_pct = 0;
      end
      IDLE_SINK: begin
        gap_pct = 0;
        stall_pct = 50;
      end
      default: begin
        gap_pct = 6;
        stall_pct = 6;
      end
    endcase
  endtask

  task automatic send_request(input req_t r);
    @(negedge clk);
    while ($urandom_range(0, 99) < gap_pct) begin
      req_bus.valid <= 1'b0;
      @(negedge clk);
    end
    req_bus.valid <= 1'b1;
    req_bus.req_type <= r.req_type;
    req_bus.center_x <= r.cx;
    req_bus.center_y <= r.cy;
    req_bus.radius_x <= r.rx;
    req_bus.radius_y <= r.ry;
    req_bus.color <= r.colour;
    do @(posedge clk); while (!req_bus.ready);
    trace_request(r);
  endtask

  task automatic start_ellipse(input logic [CW-1:0] cx, input logic [CW-1:0] cy,
                               input logic [RW-1:0] rx, input logic [RW-1:0] ry,
                               input logic [COLOR_BITS-1:0] colour);
    req_t r;
    r.req_type = REQ_START;
    r.cx = cx;
    r.cy = cy;
    r.rx = rx;
    r.ry = ry;
    r.colour = colour;
    send_request(r);
  endtask

  // the other fields are don't-care on an advance, so scramble them
  task automatic advance_point();
    req_t r;
    r = req_t'({$urandom, $urandom, $urandom});
    r.req_type = REQ_ADVANCE;
    send_request(r);
  endtask

  task automatic drain_pixels();
    @(negedge clk);
    req_bus.valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
  endtask

  function automatic logic [RW-1:0] pick_radius();
    if ($urandom_range(0, 7) == 0) return RW'($urandom_range(1, 80));
    return RW'($urandom_range(1, 16));
  endfunction

  task automatic test_idle_and_zero_radius();
    advance_point();
    start_ellipse(100, 200, 0, 5, 24'h123456);
    advance_point();
    start_ellipse(100, 200, 7, 0, 24'h654321);
    advance_point();
    start_ellipse(100, 200, 0, 0, 24'habcdef);
    advance_point();
  endtask

  task automatic test_field_extremes();
    start_ellipse(4095, 4095, 2047, 2047, 24'hffffff);
    repeat (2) advance_point();
    // restarting mid-ellipse drops the old one
    start_ellipse(0, 0, 2047, 1, 24'h000000);
    repeat (2) advance_point();
    // tall and thin: crosses into region two on the second point
    start_ellipse(0, 4095, 1, 2047, 24'h5a5a5a);
    repeat (3) advance_point();
  endtask

  task automatic test_small_ellipses();
    start_ellipse(2048, 1024, 1, 1, 24'hc3c3c3);
    while (tracing) advance_point();
    start_ellipse(17, 33, 3, 2, 24'h3c3c3c);
    while (tracing) advance_point();
    advance_point();
  endtask

  task automatic test_random_ellipses();
    int counted;
    int pick;
    int steps;
    int stop_at;
    counted = 0;
    while (counted < RANDOM_ITEMS) begin
      set_idling(idling_t'((counted / 100) % 4));
      pick = $urandom_range(0, 99);
      if (pick < 80) begin
        start_ellipse(CW'($urandom_range(0, 4095)), CW'($urandom_range(0, 4095)),
                      pick_radius(), pick_radius(), COLOR_BITS'($urandom));
        counted++;
        stop_at = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 8) : 0;
        steps = 0;
        while (tracing && (stop_at == 0 || steps < stop_at)) begin
          advance_point();
          steps++;
          counted++;
        end
        if ($urandom_range(0, 19) == 0) drain_pixels();
      end else if (pick < 90) begin
        // full-width radii, cut short after a few points
        start_ellipse(CW'($urandom_range(0, 4095)), CW'($urandom_range(0, 4095)),
                      RW'($urandom_range(0, 2047)), RW'($urandom_range(0, 2047)),
                      COLOR_BITS'($urandom));
        counted++;
        repeat ($urandom_range(0, 5)) begin
          if (tracing) counted++;
          advance_point();
        end
      end else if ($urandom_range(0, 1) == 0) begin
        pick = $urandom_range(0, 2);
        start_ellipse(CW'($urandom_range(0, 4095)), CW'($urandom_range(0, 4095)),
                      RW'((pick == 1) ? $urandom_range(1, 2047) : 0),
                      RW'((pick == 2) ? $urandom_range(1, 2047) : 0),
                      COLOR_BITS'($urandom));
        counted++;
      end else begin
        if (tracing) counted++;
        advance_point();
      end
    end
  endtask

  task automatic compare_field(input string name, input longint want, input longint got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : check_pixels
    pixel_t want;
    if (rst_n && pixel_bus.valid && pixel_bus.ready) begin
      if (pending_pixels.size() == 0) begin
        $display("%0t: unexpected pixel beat, expected none, got (%0d,%0d,%0d,%0d)",
                 $time, pixel_bus.px_right, pixel_bus.px_left, pixel_bus.py_down,
                 pixel_bus.py_up);
        mismatches++;
      end else begin
        want = pending_pixels.pop_front();
        compare_field("px_right", longint'(want.right), longint'(pixel_bus.px_right));
        compare_field("px_left", longint'(want.left), longint'(pixel_bus.px_left));
        compare_field("py_down", longint'(want.down), longint'(pixel_bus.py_down));
        compare_field("py_up", longint'(want.up), longint'(pixel_bus.py_up));
        compare_field("pixel_color", longint'(want.colour),
                      longint'(pixel_bus.pixel_color));
        compare_field("last_point", longint'(want.last), longint'(pixel_bus.last_point));
      end
    end
  end

  always @(negedge clk) pixel_bus.ready <= ($urandom_range(0, 99) >= stall_pct);

  always @(posedge clk) begin
    if ((req_bus.valid && req_bus.ready) || (pixel_bus.valid && pixel_bus.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    quiet_cycles = 0;
    mismatches = 0;
    tracing = 1'b0;
    second_region = 1'b0;
    set_idling(IDLE_NONE);
    pixel_bus.ready = 1'b0;
    req_bus.valid = 1'b0;
    req_bus.req_type = REQ_START;
    req_bus.center_x = '0;
    req_bus.center_y = '0;
    req_bus.radius_x = '0;
    req_bus.radius_y = '0;
    req_bus.color = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_idle_and_zero_radius();
    test_field_extremes();
    test_small_ellipses();
    drain_pixels();
    test_random_ellipses();

    drain_pixels();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_pixels.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
